### src/gple_pkg.sv
// Shared types and constants of the group prefix letter encoder.
package gple_pkg;

  // Width of the saturating per-message bit counter.
  localparam int unsigned CountW = 24;
  // Width of the total bit count carried on the output port.
  localparam int unsigned TotalW = 24;

  localparam int unsigned CodeW = 6;
  localparam int unsigned LenW  = 3;

  localparam logic [7:0] CharA = 8'h61;
  localparam logic [7:0] CharB = 8'h62;
  localparam logic [7:0] CharC = 8'h63;
  localparam logic [7:0] CharF = 8'h66;
  localparam logic [7:0] CharG = 8'h67;
  localparam logic [7:0] CharN = 8'h6e;
  localparam logic [7:0] CharO = 8'h6f;
  localparam logic [7:0] CharZ = 8'h7a;

  // One classified character as it waits between the front and the back.
  typedef struct packed {
    logic [CodeW-1:0] code;  // group number in bits 1:0, index above
    logic [LenW-1:0]  len;   // code length, zero for a character without code
    logic             last;  // message end
  } item_t;

endpackage

### src/gple_front.sv
// Front end: accepts characters and turns each into a code and its length.
module gple_front import gple_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       message_end_i,
  output logic       push_o,
  output item_t      push_item_o,
  input  logic       full_i
);

  logic [1:0] grp;
  logic [7:0] base;
  logic       coded;
  logic [3:0] idx;

  always_comb begin
    grp   = 2'd0;
    base  = CharA;
    coded = 1'b1;
    if (char_byte_i inside {[CharA:CharB]}) begin
      grp  = 2'd0;
      base = CharA;
    end else if (char_byte_i inside {[CharC:CharF]}) begin
      grp  = 2'd1;
      base = CharC;
    end else if (char_byte_i inside {[CharG:CharN]}) begin
      grp  = 2'd2;
      base = CharG;
    end else if (char_byte_i inside {[CharO:CharZ]}) begin
      grp  = 2'd3;
      base = CharO;
    end else begin
      coded = 1'b0;
    end
  end

  assign idx = 4'(char_byte_i - base);

  always_comb begin
    push_item_o.last = message_end_i;
    if (coded) begin
      push_item_o.code = {idx, grp};
      push_item_o.len  = LenW'({1'b0, grp} + 3'd3);
    end else begin
      push_item_o.code = '0;
      push_item_o.len  = '0;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

### src/gple_fifo.sv
// Two-entry queue that decouples the classifying front from the packing back.
module gple_fifo import gple_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  pop_valid_o,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### src/gple_back.sv
// Back end: packs code bits into bytes, keeps the total and drives the output register.
module gple_back import gple_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        packed_byte_o,
  output logic [3:0]        valid_bits_o,
  output logic [TotalW-1:0] total_bits_o,
  output logic              run_last_o
);

  logic [7:0]        pend_bits_q, pend_bits_d;
  logic [2:0]        pend_cnt_q, pend_cnt_d;
  logic [CountW-1:0] total_q, total_d;
  logic              flush_q, flush_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        byte_q, byte_d;
  logic [3:0]        nbits_q, nbits_d;
  logic [CountW-1:0] otot_q, otot_d;
  logic              last_q, last_d;

  logic              can_load;
  logic [12:0]       acc;
  logic [3:0]        cnt;
  logic [CountW:0]   sum;
  logic [CountW-1:0] total_new;
  logic              full_byte;
  logic              emits;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    acc       = 13'(pend_bits_q) | (13'(item_i.code) << pend_cnt_q);
    cnt       = 4'(pend_cnt_q) + 4'(item_i.len);
    sum       = {1'b0, total_q} + (CountW+1)'(item_i.len);
    total_new = sum[CountW] ? {CountW{1'b1}} : sum[CountW-1:0];
    full_byte = cnt[3];
    emits     = full_byte || item_i.last;
  end

  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    total_d     = total_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    nbits_d     = nbits_q;
    otot_d      = otot_q;
    last_d      = last_q;
    pop_o       = 1'b0;

    if (flush_q) begin
      // Message end that followed a full byte: send what is left.
      if (can_load) begin
        out_valid_d = 1'b1;
        byte_d      = pend_bits_q;
        nbits_d     = 4'(pend_cnt_q);
        otot_d      = total_q;
        last_d      = 1'b1;
        pend_bits_d = '0;
        pend_cnt_d  = '0;
        total_d     = '0;
        flush_d     = 1'b0;
      end
    end else if (item_valid_i && (can_load || !emits)) begin
      pop_o = 1'b1;
      if (item_i.len != '0) begin
        total_d = total_new;
      end
      if (full_byte) begin
        out_valid_d = 1'b1;
        byte_d      = acc[7:0];
        nbits_d     = 4'd8;
        otot_d      = total_new;
        last_d      = 1'b0;
        pend_bits_d = {3'b000, acc[12:8]};
        pend_cnt_d  = cnt[2:0];
        flush_d     = item_i.last;
      end else if (item_i.last) begin
        out_valid_d = 1'b1;
        byte_d      = acc[7:0];
        nbits_d     = cnt;
        otot_d      = (item_i.len != '0) ? total_new : total_q;
        last_d      = 1'b1;
        pend_bits_d = '0;
        pend_cnt_d  = '0;
        total_d     = '0;
      end else begin
        pend_bits_d = acc[7:0];
        pend_cnt_d  = cnt[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      total_q     <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      total_q     <= total_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    nbits_q <= nbits_d;
    otot_q  <= otot_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign valid_bits_o  = nbits_q;
  assign total_bits_o  = TotalW'(otot_q);
  assign run_last_o    = last_q;

endmodule

### src/group_prefix_letter_encoder.sv
// Top level of the group prefix letter encoder: front, queue and packing back.
//
// Usage: one character word enters on the input channel (in_valid_i /
// in_ready_o) with char_byte_i and message_end_i. Lower-case letters become
// 3- to 6-bit codes, a 2-bit group number followed by the index within the
// group, packed least significant bit first. Every other byte adds no bits.
// A result word leaves on the output channel (out_valid_o / out_ready_i)
// whenever a byte fills up, and on message end a final word with
// run_last_o set carries the partial byte, its bit count and the message's
// saturating bit total; the packing state then clears.
// An accepted character is held in the queue, and its result word is then
// registered in the packer's output register before it leaves.
// Throughput: one character per cycle while the receiver keeps up. A
// character that both fills a byte and ends the message makes two words; the
// packer takes no character from the queue while it sends the second one.
// The two-entry queue absorbs the input while the output register waits.
// When the receiver stalls, the output word holds, the packer stops once a
// word is due, the queue fills and in_ready_o falls; nothing is lost.
// Reset clears the queue, the packing state, the total and the output valid.
module group_prefix_letter_encoder import gple_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_byte_i,
  input  logic              message_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        packed_byte_o,
  output logic [3:0]        valid_bits_o,
  output logic [TotalW-1:0] total_bits_o,
  output logic              run_last_o
);

  logic  push;
  item_t push_item;
  logic  full;
  logic  pop;
  logic  pop_valid;
  item_t pop_item;

  // Classification of each accepted character into code and length.
  gple_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_byte_i   (char_byte_i),
    .message_end_i (message_end_i),
    .push_o        (push),
    .push_item_o   (push_item),
    .full_i        (full)
  );

  // Short queue so that the front keeps accepting while the back stalls.
  gple_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item)
  );

  // Bit packing, total count and the output register.
  gple_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (pop_valid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .valid_bits_o  (valid_bits_o),
    .total_bits_o  (total_bits_o),
    .run_last_o    (run_last_o)
  );

endmodule

### test/group_prefix_letter_encoder_test.sv
// Self-checking testbench for the group prefix letter encoder.
`timescale 1ns / 1ps

module group_prefix_letter_encoder_test;
  import gple_pkg::*;

  // One result word as it leaves the output channel.
  typedef struct packed {
    logic [7:0]        packed_byte;
    logic [3:0]        valid_bits;
    logic [TotalW-1:0] total_bits;
    logic              run_last;
  } enc_word_t;

  // Keeps its own copy of the packing state, turns every accepted character
  // into the words it must cause and compares the words that come out.
  class encode_scoreboard;
    enc_word_t         due_words[$];
    logic [7:0]        pend_bits;
    int unsigned       pend_cnt;
    logic [CountW-1:0] msg_total;
    int                errors;

    function new();
      pend_bits = '0;
      pend_cnt  = 0;
      msg_total = '0;
      errors    = 0;
    endfunction

    function void note_char(logic [7:0] ch, logic msg_end);
      logic [5:0]      code;
      int unsigned     len;
      logic [13:0]     acc;
      int unsigned     cnt;
      logic [CountW:0] grown;
      enc_word_t       w;
      code = '0;
      len  = 0;
      if (ch >= CharA && ch <= CharB) begin
        code = {4'(ch - CharA), 2'd0};
        len  = 3;
      end else if (ch >= CharC && ch <= CharF) begin
        code = {4'(ch - CharC), 2'd1};
        len  = 4;
      end else if (ch >= CharG && ch <= CharN) begin
        code = {4'(ch - CharG), 2'd2};
        len  = 5;
      end else if (ch >= CharO && ch <= CharZ) begin
        code = {4'(ch - CharO), 2'd3};
        len  = 6;
      end
      if (len != 0) begin
        acc = 14'(pend_bits) | (14'(code) << pend_cnt);
        cnt = pend_cnt + len;
        grown = {1'b0, msg_total} + (CountW+1)'(len);
        msg_total = grown[CountW] ? '1 : grown[CountW-1:0];
        if (cnt >= 8) begin
          w = '{packed_byte: acc[7:0], valid_bits: 4'd8,
                total_bits: TotalW'(msg_total), run_last: 1'b0};
          due_words.push_back(w);
          acc = acc >> 8;
          cnt = cnt - 8;
        end
        pend_bits = 8'(acc & ((14'd1 << cnt) - 14'd1));
        pend_cnt  = cnt;
      end
      if (msg_end) begin
        w = '{packed_byte: pend_bits, valid_bits: 4'(pend_cnt),
              total_bits: TotalW'(msg_total), run_last: 1'b1};
        due_words.push_back(w);
        pend_bits = '0;
        pend_cnt  = 0;
        msg_total = '0;
      end
    endfunction

    function void check_word(enc_word_t got);
      enc_word_t want;
      if (due_words.size() == 0) begin
        $error("unexpected word: packed_byte %0h valid_bits %0d", got.packed_byte,
               got.valid_bits);
        errors++;
        return;
      end
      want = due_words.pop_front();
      if (got.packed_byte !== want.packed_byte) begin
        $error("packed_byte: expected %0h, got %0h", want.packed_byte, got.packed_byte);
        errors++;
      end
      if (got.valid_bits !== want.valid_bits) begin
        $error("valid_bits: expected %0d, got %0d", want.valid_bits, got.valid_bits);
        errors++;
      end
      if (got.total_bits !== want.total_bits) begin
        $error("total_bits: expected %0d, got %0d", want.total_bits, got.total_bits);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_words.size();
    endfunction
  endclass

  localparam int HoldCycles = 80;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        char_byte_i;
  logic              message_end_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        packed_byte_o;
  logic [3:0]        valid_bits_o;
  logic [TotalW-1:0] total_bits_o;
  logic              run_last_o;

  encode_scoreboard board;
  int idle_pct;
  int stall_pct;
  bit hold_request;
  int sent;

  group_prefix_letter_encoder i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .char_byte_i,
    .message_end_i,
    .out_valid_o,
    .out_ready_i,
    .packed_byte_o,
    .valid_bits_o,
    .total_bits_o,
    .run_last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one character word and returns once it is taken, after an
  // optional idle gap. Valid is only lowered when a gap follows.
  task automatic send_char(input logic [7:0] ch, input logic msg_end);
    int gap;
    in_valid_i    <= 1'b1;
    char_byte_i   <= ch;
    message_end_i <= msg_end;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    board.note_char(ch, msg_end);
    sent++;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every predicted word has been checked.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly lower-case letters, now and then any byte at all.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(9) < 8) return CharA + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // A message of random content that always closes with message end.
  task automatic send_message();
    int len;
    if ($urandom_range(19) == 0) len = $urandom_range(300, 100);
    else len = $urandom_range(20, 1);
    for (int i = 1; i < len; i++) send_char(pick_char(), 1'b0);
    send_char(pick_char(), 1'b1);
  endtask

  // Random traffic until this phase has moved its share of characters; a few
  // lone random bytes that end a message on their own mix in as noise.
  task automatic random_phase(input int quota);
    int start;
    start = sent;
    while (sent - start < quota) begin
      if ($urandom_range(15) == 0) send_char(8'($urandom_range(255)), 1'b1);
      else send_message();
    end
  endtask

  // Output side: checks each accepted word, then picks next cycle's ready.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        board.check_word('{packed_byte: packed_byte_o, valid_bits: valid_bits_o,
                           total_bits: total_bits_o, run_last: run_last_o});
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    board         = new();
    idle_pct      = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    sent          = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    char_byte_i   <= 8'h00;
    message_end_i <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: group edges, bytes just outside the letters, the byte
    // extremes, an empty flush, and a letter that fills a byte and ends the
    // message at once.
    send_char(8'h00, 1'b1);
    send_char(CharA, 1'b0);
    send_char(CharB, 1'b0);
    send_char(CharC, 1'b0);
    send_char(CharF, 1'b0);
    send_char(CharG, 1'b0);
    send_char(CharN, 1'b0);
    send_char(CharO, 1'b0);
    send_char(CharZ, 1'b1);
    send_char(8'h60, 1'b0);
    send_char(8'h7b, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(CharZ, 1'b0);
    send_char(CharO, 1'b0);
    send_char(CharN, 1'b1);
    send_char(8'h41, 1'b1);
    send_char(CharZ - 8'd1, 1'b0);
    send_char(CharA, 1'b0);
    send_char(8'h80, 1'b1);
    wait_drained();

    random_phase(220);

    // Receiver holds off while letters keep coming, so the queue fills and
    // the input stalls.
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_char(CharZ - 8'($urandom_range(11)), 1'b0);
    send_char(CharZ, 1'b1);
    wait_drained();

    idle_pct = 74;
    random_phase(220);
    wait_drained();

    idle_pct  = 0;
    stall_pct = 74;
    random_phase(220);
    wait_drained();

    idle_pct  = 20;
    stall_pct = 20;
    random_phase(220);

    idle_pct  = 0;
    stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
src/gple_pkg.sv
src/gple_front.sv
src/gple_fifo.sv
src/gple_back.sv
src/group_prefix_letter_encoder.sv
test/group_prefix_letter_encoder_test.sv
